// ===== hdl/vma_pkg.sv =====
// ----------------------------------------------------------------------------
// vma_pkg
// Types, constants and the operation sequence of the velocity moment
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package vma_pkg;

  localparam int VMA_BLOCK_WIDTH   = 4;
  localparam int VMA_FRACTION_BITS = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_VX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_VY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_VZ   = 2'd3;

  localparam int NUM_SUMS = 6;
  localparam int STEP_W   = 4;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic signed [31:0] corner_vx;
    logic signed [31:0] corner_vy;
    logic signed [31:0] corner_vz;
    logic [30:0]        step_vx;
    logic [30:0]        step_vy;
    logic [30:0]        step_vz;
    logic [1:0]         cell_x;
    logic [1:0]         cell_y;
    logic [1:0]         cell_z;
    logic               end_of_cell;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] sum_zero;
    logic signed [63:0] sum_one;
    logic signed [63:0] sum_two;
    logic signed [63:0] sum_three;
    logic signed [63:0] sum_four;
    logic signed [63:0] sum_five;
    logic               saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    UOP_MUL,
    UOP_SUB,
    UOP_ACC,
    UOP_END
  } uop_op_t;

  typedef enum logic [4:0] {
    OPD_F,
    OPD_SX,
    OPD_SY,
    OPD_SZ,
    OPD_VX,
    OPD_VY,
    OPD_VZ,
    OPD_MX,
    OPD_MY,
    OPD_MZ,
    OPD_T,
    OPD_DV,
    OPD_FDV,
    OPD_FX,
    OPD_FY,
    OPD_DX,
    OPD_DY,
    OPD_DZ,
    OPD_ACC
  } opnd_t;

  typedef struct packed {
    uop_op_t     op;
    opnd_t       a;
    opnd_t       b;
    opnd_t       dst;
    logic [2:0]  acc;
  } uop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_FIN,
    ST_SUB,
    ST_MOVE,
    ST_WB,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        load;
    logic        fetch;
    logic        pp_step;
    logic [1:0]  pp_idx;
    logic        fin;
    logic        sub;
    logic        move;
    logic        wb;
    logic        emit;
    uop_t        uop;
  } cmd_t;

  typedef struct packed {
    logic pass_mode;
  } stat_t;

  function automatic uop_t mk(uop_op_t op, opnd_t a, opnd_t b, opnd_t dst,
                              logic [2:0] acc);
    uop_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.dst = dst;
    u.acc = acc;
    return u;
  endfunction

  // operation sequence per item; mode 0 first moments, mode 1 pressure tensor
  function automatic uop_t uop_f(logic mode, logic [STEP_W-1:0] step);
    uop_t u;
    u = mk(UOP_END, OPD_F, OPD_F, OPD_T, 3'd0);
    if (!mode) begin
      case (step)
        4'd0: u = mk(UOP_MUL, OPD_SX,  OPD_SY, OPD_T,   3'd0);
        4'd1: u = mk(UOP_MUL, OPD_T,   OPD_SZ, OPD_DV,  3'd0);
        4'd2: u = mk(UOP_MUL, OPD_F,   OPD_DV, OPD_FDV, 3'd0);
        4'd3: u = mk(UOP_ACC, OPD_FDV, OPD_F,  OPD_ACC, 3'd0);
        4'd4: u = mk(UOP_MUL, OPD_FDV, OPD_VX, OPD_ACC, 3'd1);
        4'd5: u = mk(UOP_MUL, OPD_FDV, OPD_VY, OPD_ACC, 3'd2);
        4'd6: u = mk(UOP_MUL, OPD_FDV, OPD_VZ, OPD_ACC, 3'd3);
        default: u = mk(UOP_END, OPD_F, OPD_F, OPD_T, 3'd0);
      endcase
    end else begin
      case (step)
        4'd0:  u = mk(UOP_SUB, OPD_VX,  OPD_MX, OPD_DX,  3'd0);
        4'd1:  u = mk(UOP_SUB, OPD_VY,  OPD_MY, OPD_DY,  3'd0);
        4'd2:  u = mk(UOP_SUB, OPD_VZ,  OPD_MZ, OPD_DZ,  3'd0);
        4'd3:  u = mk(UOP_MUL, OPD_SX,  OPD_SY, OPD_T,   3'd0);
        4'd4:  u = mk(UOP_MUL, OPD_T,   OPD_SZ, OPD_DV,  3'd0);
        4'd5:  u = mk(UOP_MUL, OPD_F,   OPD_DV, OPD_FDV, 3'd0);
        4'd6:  u = mk(UOP_MUL, OPD_FDV, OPD_DX, OPD_FX,  3'd0);
        4'd7:  u = mk(UOP_MUL, OPD_FDV, OPD_DY, OPD_FY,  3'd0);
        4'd8:  u = mk(UOP_MUL, OPD_FX,  OPD_DX, OPD_ACC, 3'd0);
        4'd9:  u = mk(UOP_MUL, OPD_FY,  OPD_DY, OPD_ACC, 3'd1);
        4'd10: u = mk(UOP_MUL, OPD_FDV, OPD_DZ, OPD_T,   3'd0);
        4'd11: u = mk(UOP_MUL, OPD_T,   OPD_DZ, OPD_ACC, 3'd2);
        4'd12: u = mk(UOP_MUL, OPD_FY,  OPD_DZ, OPD_ACC, 3'd3);
        4'd13: u = mk(UOP_MUL, OPD_FX,  OPD_DZ, OPD_ACC, 3'd4);
        4'd14: u = mk(UOP_MUL, OPD_FX,  OPD_DY, OPD_ACC, 3'd5);
        default: u = mk(UOP_END, OPD_F, OPD_F, OPD_T, 3'd0);
      endcase
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/vma_if.sv =====
// ----------------------------------------------------------------------------
// vma_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface vma_in_if;
  import vma_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vma_out_if;
  import vma_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/vma_dpath.sv =====
// ----------------------------------------------------------------------------
// vma_dpath
// Operand registers, shared iterative Q-format multiplier, saturating
// subtract and accumulate, configuration and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vma_dpath #(
  parameter int BLOCK_WIDTH   = 4,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [vma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vma_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire vma_pkg::in_item_t                in_data,
  input  wire vma_pkg::cmd_t                    cmd,
  output vma_pkg::stat_t                        stat,
  output vma_pkg::out_item_t                    out_data
);
  import vma_pkg::*;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic [128:0]       NEG_LIM = 129'(1) << 63;

  logic               mode_r;
  logic signed [63:0] mx_r, my_r, mz_r;
  logic signed [63:0] f_r, sx_r, sy_r, sz_r, vx_r, vy_r, vz_r;
  logic signed [63:0] t_r, dv_r, fdv_r, fx_r, fy_r, dx_r, dy_r, dz_r;
  logic signed [63:0] a_r, b_r, r_r;
  logic [63:0]        xm_r, ym_r;
  logic               neg_r;
  logic [127:0]       prod_r;
  logic signed [63:0] acc_r [NUM_SUMS];
  logic               sat_r;
  out_item_t          out_r;

  function automatic logic [1:0] clamp_idx(logic [1:0] c);
    if (32'(c) > BLOCK_WIDTH - 1) return 2'(BLOCK_WIDTH - 1);
    return c;
  endfunction

  // corner + (index + 0.5) * step
  function automatic logic signed [63:0] centre(logic signed [31:0] corner,
                                                logic [30:0] step,
                                                logic [1:0] c);
    logic [2:0]  odd;
    logic [33:0] p;
    odd = {clamp_idx(c), 1'b1};
    p   = 34'(odd) * 34'(step);
    return 64'(corner) + 64'(p[33:1]);
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  logic signed [63:0] opa, opb;

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.uop.a)
      OPD_F:   opa = f_r;
      OPD_SX:  opa = sx_r;
      OPD_SY:  opa = sy_r;
      OPD_SZ:  opa = sz_r;
      OPD_VX:  opa = vx_r;
      OPD_VY:  opa = vy_r;
      OPD_VZ:  opa = vz_r;
      OPD_MX:  opa = mx_r;
      OPD_MY:  opa = my_r;
      OPD_MZ:  opa = mz_r;
      OPD_T:   opa = t_r;
      OPD_DV:  opa = dv_r;
      OPD_FDV: opa = fdv_r;
      OPD_FX:  opa = fx_r;
      OPD_FY:  opa = fy_r;
      OPD_DX:  opa = dx_r;
      OPD_DY:  opa = dy_r;
      OPD_DZ:  opa = dz_r;
      default: opa = '0;
    endcase
    case (cmd.uop.b)
      OPD_F:   opb = f_r;
      OPD_SX:  opb = sx_r;
      OPD_SY:  opb = sy_r;
      OPD_SZ:  opb = sz_r;
      OPD_VX:  opb = vx_r;
      OPD_VY:  opb = vy_r;
      OPD_VZ:  opb = vz_r;
      OPD_MX:  opb = mx_r;
      OPD_MY:  opb = my_r;
      OPD_MZ:  opb = mz_r;
      OPD_T:   opb = t_r;
      OPD_DV:  opb = dv_r;
      OPD_FDV: opb = fdv_r;
      OPD_FX:  opb = fx_r;
      OPD_FY:  opb = fy_r;
      OPD_DX:  opb = dx_r;
      OPD_DY:  opb = dy_r;
      OPD_DZ:  opb = dz_r;
      default: opb = '0;
    endcase
  end

  // one 32x32 partial product per cycle
  logic [31:0]  xh, yh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] prod_nxt;

  always_comb begin
    xh = cmd.pp_idx[1] ? xm_r[63:32] : xm_r[31:0];
    yh = cmd.pp_idx[0] ? ym_r[63:32] : ym_r[31:0];
    pp = 64'(xh) * 64'(yh);
    case (cmd.pp_idx)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
    prod_nxt = ((cmd.pp_idx == 2'd0) ? 128'd0 : prod_r) + pp_sh;
  end

  // floor to fraction bits and saturate
  logic [127:0]       q;
  logic               rem;
  logic [128:0]       qq;
  logic signed [63:0] mul_res;
  logic               mul_sat;

  always_comb begin
    q       = prod_r >> FRACTION_BITS;
    rem     = |prod_r[FRACTION_BITS-1:0];
    qq      = 129'(q) + 129'(rem);
    mul_sat = 1'b0;
    if (neg_r) begin
      if (qq > NEG_LIM) begin
        mul_sat = 1'b1;
        mul_res = S64_MIN;
      end else begin
        mul_res = -$signed(qq[63:0]);
      end
    end else begin
      if (q > 128'(S64_MAX)) begin
        mul_sat = 1'b1;
        mul_res = S64_MAX;
      end else begin
        mul_res = $signed(q[63:0]);
      end
    end
  end

  logic signed [64:0] diff, asum;
  logic signed [63:0] acc_sel;

  always_comb begin
    diff    = 65'(a_r) - 65'(b_r);
    acc_sel = acc_r[cmd.uop.acc];
    asum    = 65'(acc_sel) + 65'(r_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      mx_r   <= '0;
      my_r   <= '0;
      mz_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PASS_MODE: mode_r <= cfg_data[0];
        CFG_MEAN_VX:   mx_r   <= 64'($signed(cfg_data));
        CFG_MEAN_VY:   my_r   <= 64'($signed(cfg_data));
        CFG_MEAN_VZ:   mz_r   <= 64'($signed(cfg_data));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_r  <= 64'(in_data.sample_value);
      sx_r <= 64'(in_data.step_vx);
      sy_r <= 64'(in_data.step_vy);
      sz_r <= 64'(in_data.step_vz);
      vx_r <= centre(in_data.corner_vx, in_data.step_vx, in_data.cell_x);
      vy_r <= centre(in_data.corner_vy, in_data.step_vy, in_data.cell_y);
      vz_r <= centre(in_data.corner_vz, in_data.step_vz, in_data.cell_z);
    end
    if (cmd.fetch) begin
      a_r   <= opa;
      b_r   <= opb;
      xm_r  <= mag(opa);
      ym_r  <= mag(opb);
      neg_r <= opa[63] ^ opb[63];
    end
    if (cmd.pp_step) prod_r <= prod_nxt;
    if (cmd.fin) r_r <= mul_res;
    if (cmd.move) r_r <= a_r;
    if (cmd.sub) begin
      if (diff[64] != diff[63]) r_r <= diff[64] ? S64_MIN : S64_MAX;
      else r_r <= diff[63:0];
    end
    if (cmd.wb) begin
      case (cmd.uop.dst)
        OPD_T:   t_r   <= r_r;
        OPD_DV:  dv_r  <= r_r;
        OPD_FDV: fdv_r <= r_r;
        OPD_FX:  fx_r  <= r_r;
        OPD_FY:  fy_r  <= r_r;
        OPD_DX:  dx_r  <= r_r;
        OPD_DY:  dy_r  <= r_r;
        OPD_DZ:  dz_r  <= r_r;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_r.sum_zero  <= acc_r[0];
      out_r.sum_one   <= acc_r[1];
      out_r.sum_two   <= acc_r[2];
      out_r.sum_three <= acc_r[3];
      out_r.sum_four  <= mode_r ? acc_r[4] : 64'sd0;
      out_r.sum_five  <= mode_r ? acc_r[5] : 64'sd0;
      out_r.saturated <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SUMS; k++) acc_r[k] <= '0;
      sat_r <= 1'b0;
    end else if (cmd.emit) begin
      for (int k = 0; k < NUM_SUMS; k++) acc_r[k] <= '0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.fin && mul_sat) sat_r <= 1'b1;
      if (cmd.sub && (diff[64] != diff[63])) sat_r <= 1'b1;
      if (cmd.wb && cmd.uop.dst == OPD_ACC) begin
        if (asum[64] != asum[63]) begin
          sat_r <= 1'b1;
          acc_r[cmd.uop.acc] <= asum[64] ? S64_MIN : S64_MAX;
        end else begin
          acc_r[cmd.uop.acc] <= asum[63:0];
        end
      end
    end
  end

  assign stat.pass_mode = mode_r;
  assign out_data       = out_r;

endmodule

`default_nettype wire

// ===== hdl/vma_ctrl.sv =====
// ----------------------------------------------------------------------------
// vma_ctrl
// Sequencer: walks the operation list of the current mode for each item and
// drives the datapath, the input ready and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module vma_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_end,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire vma_pkg::stat_t  stat,
  output vma_pkg::cmd_t        cmd
);
  import vma_pkg::*;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [1:0]          pp_r, pp_nxt;
  logic                end_r, end_nxt;
  logic                out_valid_r, out_valid_nxt;
  uop_t                uop;
  logic                out_free;

  assign uop      = uop_f(stat.pass_mode, step_r);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pp_nxt    = pp_r;
    end_nxt   = end_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FETCH;
          step_nxt  = '0;
          end_nxt   = in_end;
        end
      end
      ST_FETCH: begin
        unique case (uop.op)
          UOP_MUL: begin
            state_nxt = ST_MUL;
            pp_nxt    = 2'd0;
          end
          UOP_SUB: state_nxt = ST_SUB;
          UOP_ACC: state_nxt = ST_MOVE;
          UOP_END: state_nxt = end_r ? ST_EMIT : ST_IDLE;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_MUL: begin
        pp_nxt = pp_r + 2'd1;
        if (pp_r == 2'd3) state_nxt = ST_FIN;
      end
      ST_FIN, ST_SUB, ST_MOVE: state_nxt = ST_WB;
      ST_WB: begin
        state_nxt = ST_FETCH;
        step_nxt  = step_r + 1'b1;
      end
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.uop     = uop;
    cmd.pp_idx  = pp_r;
    in_ready    = (state_r == ST_IDLE);
    cmd.load    = (state_r == ST_IDLE) && in_valid;
    cmd.fetch   = (state_r == ST_FETCH);
    cmd.pp_step = (state_r == ST_MUL);
    cmd.fin     = (state_r == ST_FIN);
    cmd.sub     = (state_r == ST_SUB);
    cmd.move    = (state_r == ST_MOVE);
    cmd.wb      = (state_r == ST_WB);
    cmd.emit    = (state_r == ST_EMIT) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      pp_r        <= '0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      pp_r        <= pp_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_FETCH && step_r == '0))
    else $error("accepted request did not start the sequence");

  a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && pp_r == 2'd3) |=> (state_r == ST_FIN))
    else $error("multiply did not finish after four partial products");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_wb_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |=> (state_r == ST_FETCH && step_r == $past(step_r) + 1'b1))
    else $error("sequence step not advanced after write back");

endmodule

`default_nettype wire

// ===== hdl/velocity_moment_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// velocity_moment_accumulator_top
// Accumulates density/momentum or pressure-tensor sums over velocity cells.
//
//   channel   dir   handshake      payload
//   in_chan   in    valid/ready    vma_pkg::in_item_t (one velocity cell)
//   out_chan  out   valid/ready    vma_pkg::out_item_t (sums, on last cell)
//   cfg_*     in    write enable   pass_mode, mean_vx, mean_vy, mean_vz
//
// one item at a time: a shared 32x32 multiplier builds each 64-bit product
// from partial products; a product steps through fetch, multiply, finish,
// write-back, a subtract or add through fetch, subtract or move, write-back
// synchronous active-low reset clears sums, flag and configuration
// the result sits in an output register; a stalled result holds the next
// emitting item in its last step, other items keep flowing
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_moment_accumulator_top #(
  parameter int BLOCK_WIDTH   = vma_pkg::VMA_BLOCK_WIDTH,
  parameter int FRACTION_BITS = vma_pkg::VMA_FRACTION_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [vma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vma_pkg::CFG_DATA_W-1:0]  cfg_data,
  vma_in_if.sink                               in_chan,
  vma_out_if.source                            out_chan
);
  import vma_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  vma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_end    (in_chan.data.end_of_cell),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vma_dpath #(
    .BLOCK_WIDTH   (BLOCK_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_chan.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_chan.data)
  );

endmodule

`default_nettype wire
